[hw/rtl/apq_pkg.sv]
// Package for the aging priority queue: sizes, codes, beat structs and cell bus types.
// No dependencies.
`default_nettype none
package apq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 10;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] PRIO_MAX      = 16'hFFFF;
	localparam logic [31:0] AGE_THRESHOLD = 32'd10;
	localparam logic [16:0] CRIT_BONUS    = 17'd10;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_AGE    = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] REG_DOM  = 2'd0;
	localparam logic [1:0] REG_INTL = 2'd1;
	localparam logic [1:0] REG_REAL = 2'd2;
	localparam logic [1:0] REG_CRIT = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [ID_BITS-1:0] requester_id;
		logic               is_domestic;
		logic               was_reallocated;
		logic [1:0]         resource_kind;
		logic [31:0]        current_time;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         entry_count;
		logic               head_valid;
		logic [ID_BITS-1:0] head_id;
		logic [15:0]        head_priority;
		logic [1:0]         head_resource;
	} out_beat_t;

	// One queue entry.
	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [15:0]        prio;
		logic [31:0]        arrival;
		logic [1:0]         res;
	} entry_t;

	// Commands broadcast to every cell.
	typedef struct packed {
		logic               ins;     // shift in new entry at first empty or lower-priority cell
		logic               rem;     // drop first cell matching id, shift up
		logic               age;     // add bonus to every cell
		logic               sweep;   // one odd/even transposition step
		logic               odd;     // sweep phase
		logic [ID_BITS-1:0] id;
		logic [31:0]        now;
		logic [15:0]        half;
		entry_t             new_e;
	} cell_cmd_t;

	// Bonus for one entry, saturated.
	function automatic logic [15:0] aged_prio(input logic [15:0] p, input logic [31:0] now,
			input logic [31:0] arr, input logic [15:0] half);
		logic [31:0] w;
		logic [63:0] prod;
		logic [31:0] q;
		logic [33:0] sum;
		begin
			w    = now - arr;
			// w/5 by reciprocal: floor(w*0xCCCCCCCD / 2^34)
			prod = 64'(w) * 64'h0000_0000_CCCC_CCCD;
			q    = {2'b00, prod[63:34]};
			sum  = 34'(p);
			if (w > AGE_THRESHOLD) sum = sum + {1'b0, q, 1'b0};
			if (w > 32'(half)) sum = sum + 34'(CRIT_BONUS);
			aged_prio = (sum > 34'(PRIO_MAX)) ? PRIO_MAX : sum[15:0];
		end
	endfunction
endpackage
`default_nettype wire

[hw/rtl/apq_cell.sv]
// One slot of the queue chain; talks to its upper and lower neighbors.
// Depends on apq_pkg.
`default_nettype none
module apq_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  apq_pkg::cell_cmd_t cmd,
	input  wire                up_valid,
	input  apq_pkg::entry_t    up_e,
	input  wire                up_take,      // upper cell consumed the new entry
	input  wire                up_hit,       // a cell above matched remove id
	input  wire                dn_valid,
	input  apq_pkg::entry_t    dn_e,
	input  wire                dn_swap,      // pair with upper cell swaps
	output logic               valid_q,
	output apq_pkg::entry_t    e_q,
	output logic               take,         // this or upper cell placed new entry
	output logic               hit,          // this or upper cell matched
	output logic               swap_dn       // this cell swaps with the lower one
);
	import apq_pkg::*;
	logic my_take, my_hit, pair_lead, up_swap_lead;

	// New entry goes in front of the first lower-priority or empty cell.
	assign my_take = !up_take && (!valid_q || e_q.prio < cmd.new_e.prio);
	assign take    = up_take || my_take;
	assign my_hit  = !up_hit && valid_q && e_q.id == cmd.id;
	assign hit     = up_hit || my_hit;
	// Sweep: leader cell swaps with lower if lower has strictly higher priority.
	assign pair_lead = cmd.sweep && dn_valid && valid_q && dn_e.prio > e_q.prio;
	assign swap_dn   = pair_lead;
	assign up_swap_lead = dn_swap;

	// Cell register update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			e_q     <= '0;
		end else if (cmd.ins) begin
			if (my_take) begin
				valid_q <= 1'b1;
				e_q     <= cmd.new_e;
			end else if (up_take) begin
				valid_q <= up_valid;
				e_q     <= up_e;
			end
		end else if (cmd.rem) begin
			if (hit) begin
				valid_q <= dn_valid;
				e_q     <= dn_e;
			end
		end else if (cmd.age) begin
			if (valid_q) e_q.prio <= aged_prio(e_q.prio, cmd.now, e_q.arrival, cmd.half);
		end else if (pair_lead) begin
			e_q <= dn_e;
		end else if (up_swap_lead) begin
			e_q <= up_e;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/aging_priority_queue.sv]
// Top level of the aging priority queue: control sequencer and the chain of cells.
// Depends on apq_pkg and apq_cell.
//
// Usage: input beats on in_valid/in_ready/in_data, results on out_valid/out_ready/
// out_data, one result per input beat. The user must write registers on cfg_we
// with cfg_index/cfg_data only while the block is idle; the block itself does
// not enforce this. Insert and remove pass through S_OP, in which every cell
// shifts in parallel, then S_OUT, which presents the result. An aging tick
// passes through S_OP, which adds the bonus in every cell, then S_SORT for
// QUEUE_DEPTH odd/even transposition steps between neighbor cells, which is a
// stable sort since only strictly ordered neighbors swap, then S_OUT. Insert
// full or remove not found leave the chain untouched. One item is handled at a
// time; in_ready is held low while an item is in flight or its result waits.
// The next beat is taken in the cycle after the result leaves.
// Reset empties the chain and restores register defaults.
// When the receiver stalls, the result register holds and no new beat is taken.
`default_nettype none
module aging_priority_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  apq_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output apq_pkg::out_beat_t  out_data,
	input  wire                 cfg_we,
	input  wire  [1:0]          cfg_index,
	input  wire  [15:0]         cfg_data
);
	import apq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_OP = 4'b0010, S_SORT = 4'b0100, S_OUT = 4'b1000
	} state_t;
	state_t state_q;

	logic [15:0] dom_q, intl_q, real_q, crit_q;
	in_beat_t    req_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [IDX_BITS:0]   step_q;
	logic [1:0]          status_q;
	cell_cmd_t cmd;

	logic   [QUEUE_DEPTH-1:0] valid, take, hit, swap_dn;
	entry_t [QUEUE_DEPTH-1:0] e;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dom_q <= 16'd10; intl_q <= 16'd20; real_q <= 16'd50; crit_q <= 16'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DOM:  dom_q  <= cfg_data;
				REG_INTL: intl_q <= cfg_data;
				REG_REAL: real_q <= cfg_data;
				REG_CRIT: crit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic full, found;
	assign full  = cnt_q == CNT_BITS'(QUEUE_DEPTH);
	assign found = hit[QUEUE_DEPTH-1];

	// Broadcast command to the cells.
	always_comb begin
		cmd = '0;
		cmd.id    = req_q.requester_id;
		cmd.now   = req_q.current_time;
		cmd.half  = {1'b0, crit_q[15:1]};
		cmd.odd   = step_q[0];
		cmd.new_e.id      = req_q.requester_id;
		cmd.new_e.arrival = req_q.current_time;
		cmd.new_e.res     = req_q.resource_kind;
		cmd.new_e.prio    = !req_q.is_domestic ? intl_q :
			(req_q.was_reallocated ? real_q : dom_q);
		if (state_q == S_OP) begin
			cmd.ins = req_q.opcode == OP_INSERT && !full;
			cmd.rem = req_q.opcode == OP_REMOVE;
			cmd.age = req_q.opcode == OP_AGE;
		end
		cmd.sweep = state_q == S_SORT;
	end

	// Chain of cells; swap leaders alternate by phase.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam bit LAST = (i == QUEUE_DEPTH - 1);
		logic   lead_ok, dn_v, up_v, up_t, up_h, dn_s;
		entry_t up_x, dn_x;
		cell_cmd_t c;
		assign lead_ok = (i % 2 == 1) == cmd.odd;
		always_comb begin
			c = cmd;
			c.sweep = cmd.sweep && lead_ok;
		end
		if (i == 0) begin : g_top
			assign up_v = 1'b0; assign up_x = '0; assign up_t = 1'b0; assign up_h = 1'b0;
		end else begin : g_mid
			assign up_v = valid[i-1]; assign up_x = e[i-1];
			assign up_t = take[i-1];  assign up_h = hit[i-1];
		end
		if (LAST) begin : g_bot
			assign dn_v = 1'b0; assign dn_x = '0;
		end else begin : g_nb
			assign dn_v = valid[i+1]; assign dn_x = e[i+1];
		end
		if (i == 0) begin : g_ns
			assign dn_s = 1'b0;
		end else begin : g_s
			assign dn_s = swap_dn[i-1];
		end
		apq_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(c),
			.up_valid(up_v), .up_e(up_x), .up_take(up_t), .up_hit(up_h),
			.dn_valid(dn_v), .dn_e(dn_x), .dn_swap(dn_s),
			.valid_q(valid[i]), .e_q(e[i]), .take(take[i]), .hit(hit[i]),
			.swap_dn(swap_dn[i])
		);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cnt_q <= '0; step_q <= '0; status_q <= ST_DONE;
			req_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					req_q   <= in_data;
					state_q <= S_OP;
				end
				S_OP: begin
					status_q <= ST_DONE;
					step_q   <= '0;
					state_q  <= S_OUT;
					case (req_q.opcode)
						OP_INSERT: if (full) status_q <= ST_FULL;
							else cnt_q <= cnt_q + 1'b1;
						OP_REMOVE: if (found) cnt_q <= cnt_q - 1'b1;
							else status_q <= ST_NOT_FOUND;
						OP_AGE: state_q <= S_SORT;
						default: ;
					endcase
				end
				S_SORT: begin
					step_q <= step_q + 1'b1;
					if (step_q == (IDX_BITS+1)'(QUEUE_DEPTH - 1)) state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	// Result beat from the head cell.
	always_comb begin
		out_data = '0;
		out_data.status      = status_q;
		out_data.entry_count = 5'(cnt_q);
		out_data.head_valid  = valid[0];
		if (valid[0]) begin
			out_data.head_id       = e[0].id;
			out_data.head_priority = e[0].prio;
			out_data.head_resource = e[0].res;
		end
	end
endmodule
`default_nettype wire

[tb/tb_aging_priority_queue.sv]
// Self-checking testbench for the aging priority queue: directed and random beats,
// randomized idling on both channels, a scoreboard class with its own queue model.
// Depends on apq_pkg and aging_priority_queue.
`default_nettype none

// Queue model and store of expected result beats.
class apq_scoreboard;
	logic [15:0] dom_prio, intl_prio, real_prio, crit_wait;
	logic [apq_pkg::ID_BITS-1:0] ids [apq_pkg::QUEUE_DEPTH];
	logic [15:0] prios [apq_pkg::QUEUE_DEPTH];
	logic [31:0] arrivals [apq_pkg::QUEUE_DEPTH];
	logic [1:0] kinds [apq_pkg::QUEUE_DEPTH];
	int count;
	int errors;
	apq_pkg::out_beat_t expected_beats [$];

	function new();
		dom_prio = 16'd10;
		intl_prio = 16'd20;
		real_prio = 16'd50;
		crit_wait = 16'd60;
		count = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [15:0] val);
		case (idx)
			apq_pkg::REG_DOM: dom_prio = val;
			apq_pkg::REG_INTL: intl_prio = val;
			apq_pkg::REG_REAL: real_prio = val;
			default: crit_wait = val;
		endcase
	endfunction

	function void move_entry(int dst, int src);
		ids[dst] = ids[src];
		prios[dst] = prios[src];
		arrivals[dst] = arrivals[src];
		kinds[dst] = kinds[src];
	endfunction

	// Update the model for one accepted input beat and queue its result.
	function void note_input(apq_pkg::in_beat_t b);
		apq_pkg::out_beat_t r;
		logic [1:0] st;
		logic [15:0] p, tp;
		logic [31:0] w, ta;
		logic [63:0] sum;
		logic [apq_pkg::ID_BITS-1:0] tid;
		logic [1:0] tr;
		int pos, j;
		st = apq_pkg::ST_DONE;
		if (b.opcode == apq_pkg::OP_INSERT) begin
			if (count >= apq_pkg::QUEUE_DEPTH) begin
				st = apq_pkg::ST_FULL;
			end else begin
				if (b.is_domestic && b.was_reallocated) p = real_prio;
				else if (b.is_domestic) p = dom_prio;
				else p = intl_prio;
				pos = 0;
				while (pos < count && prios[pos] >= p) pos++;
				for (j = count; j > pos; j--) move_entry(j, j - 1);
				ids[pos] = b.requester_id;
				prios[pos] = p;
				arrivals[pos] = b.current_time;
				kinds[pos] = b.resource_kind;
				count++;
			end
		end else if (b.opcode == apq_pkg::OP_REMOVE) begin
			st = apq_pkg::ST_NOT_FOUND;
			for (pos = 0; pos < count; pos++) begin
				if (ids[pos] == b.requester_id) break;
			end
			if (pos < count) begin
				for (j = pos; j + 1 < count; j++) move_entry(j, j + 1);
				count--;
				st = apq_pkg::ST_DONE;
			end
		end else if (b.opcode == apq_pkg::OP_AGE) begin
			for (pos = 0; pos < count; pos++) begin
				w = b.current_time - arrivals[pos];
				sum = 64'(prios[pos]);
				if (w > 32'd10) sum += 64'(w / 32'd5) * 64'd2;
				if (w > 32'(crit_wait / 16'd2)) sum += 64'd10;
				prios[pos] = (sum > 64'd65535) ? 16'hFFFF : sum[15:0];
			end
			// Stable insertion sort, highest priority first.
			for (pos = 1; pos < count; pos++) begin
				tid = ids[pos];
				tp = prios[pos];
				ta = arrivals[pos];
				tr = kinds[pos];
				j = pos;
				while (j > 0 && prios[j - 1] < tp) begin
					move_entry(j, j - 1);
					j--;
				end
				ids[j] = tid;
				prios[j] = tp;
				arrivals[j] = ta;
				kinds[j] = tr;
			end
		end
		r = '0;
		r.status = st;
		r.entry_count = 5'(count);
		if (count > 0) begin
			r.head_valid = 1'b1;
			r.head_id = ids[0];
			r.head_priority = prios[0];
			r.head_resource = kinds[0];
		end
		expected_beats.push_back(r);
	endfunction

	// Compare one result beat with the oldest expectation.
	function void check_result(apq_pkg::out_beat_t got);
		apq_pkg::out_beat_t e;
		if (expected_beats.size() == 0) begin
			$error("result beat with no expectation waiting");
			errors++;
			return;
		end
		e = expected_beats.pop_front();
		if (got.status !== e.status) begin
			$error("status expected %0d actual %0d", e.status, got.status);
			errors++;
		end
		if (got.entry_count !== e.entry_count) begin
			$error("entry_count expected %0d actual %0d", e.entry_count, got.entry_count);
			errors++;
		end
		if (got.head_valid !== e.head_valid) begin
			$error("head_valid expected %0d actual %0d", e.head_valid, got.head_valid);
			errors++;
		end
		if (got.head_id !== e.head_id) begin
			$error("head_id expected %0d actual %0d", e.head_id, got.head_id);
			errors++;
		end
		if (got.head_priority !== e.head_priority) begin
			$error("head_priority expected %0d actual %0d", e.head_priority,
				got.head_priority);
			errors++;
		end
		if (got.head_resource !== e.head_resource) begin
			$error("head_resource expected %0d actual %0d", e.head_resource,
				got.head_resource);
			errors++;
		end
	endfunction
endclass

module tb_aging_priority_queue;
	import apq_pkg::*;

	// Opcode with no operation behind it.
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_DOM;
	logic [15:0] cfg_data = '0;

	apq_scoreboard sb = new();
	bit no_idle = 0;
	logic [31:0] clock_now = 32'd1000;

	aging_priority_queue DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (no_idle || r < 6) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Drive one input beat and hold it until accepted; returns at a falling edge.
	task automatic send_beat(in_beat_t b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b);
		@(negedge clk);
	endtask

	// Let the block drain before touching registers.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_beats.size() != 0) @(negedge clk);
		repeat (QUEUE_DEPTH + 8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_all(logic [15:0] d, logic [15:0] i, logic [15:0] r, logic [15:0] c);
		drain();
		write_reg(REG_DOM, d);
		write_reg(REG_INTL, i);
		write_reg(REG_REAL, r);
		write_reg(REG_CRIT, c);
	endtask

	function automatic in_beat_t make_beat(logic [1:0] op, logic [9:0] id, logic dom,
			logic re, logic [1:0] kind, logic [31:0] t);
		in_beat_t b;
		b.opcode = op;
		b.requester_id = id;
		b.is_domestic = dom;
		b.was_reallocated = re;
		b.resource_kind = kind;
		b.current_time = t;
		return b;
	endfunction

	// Random beat shaped by the model: mostly inserts and removes of held ids.
	function automatic in_beat_t random_beat();
		int r;
		logic [9:0] id;
		r = $urandom_range(0, 99);
		id = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 23));
		if (r < 45) begin
			return make_beat(OP_INSERT, id, 1'($urandom), 1'($urandom), 2'($urandom),
				clock_now);
		end else if (r < 70) begin
			if (sb.count > 0 && $urandom_range(0, 4) != 0)
				id = sb.ids[$urandom_range(0, sb.count - 1)];
			return make_beat(OP_REMOVE, id, 1'($urandom), 1'($urandom), 2'($urandom),
				32'($urandom));
		end else if (r < 97) begin
			r = $urandom_range(0, 19);
			if (r == 0) clock_now = $urandom;
			else if (r == 1) clock_now += $urandom_range(100, 100000);
			else clock_now += $urandom_range(0, 40);
			return make_beat(OP_AGE, 10'($urandom), 1'($urandom), 1'($urandom),
				2'($urandom), clock_now);
		end
		return make_beat(OP_SPARE, 10'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
			32'($urandom));
	endfunction

	// Result side: random stalls on out_ready.
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	initial begin
		#30000000;
		$display("FAIL");
		$finish;
	end

	// Main sequence: reset, directed beats, then random phases over several settings.
	initial begin
		int n;
		int phase;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty queue, each class, extremes of fields, full, not found.
		send_beat(make_beat(OP_REMOVE, 10'h3FF, 1'b0, 1'b0, 2'd0, 32'd0));
		send_beat(make_beat(OP_AGE, 10'd0, 1'b0, 1'b0, 2'd0, 32'hFFFF_FFFF));
		send_beat(make_beat(OP_INSERT, 10'd0, 1'b1, 1'b0, 2'd0, 32'd0));
		send_beat(make_beat(OP_INSERT, 10'h3FF, 1'b0, 1'b1, 2'd3, 32'hFFFF_FFFF));
		send_beat(make_beat(OP_INSERT, 10'd5, 1'b1, 1'b1, 2'd1, 32'd5));
		send_beat(make_beat(OP_INSERT, 10'd6, 1'b0, 1'b0, 2'd2, 32'd7));
		send_beat(make_beat(OP_SPARE, 10'h3FF, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF));
		send_beat(make_beat(OP_AGE, 10'd0, 1'b0, 1'b0, 2'd0, 32'd11));
		send_beat(make_beat(OP_AGE, 10'd0, 1'b0, 1'b0, 2'd0, 32'd40));
		send_beat(make_beat(OP_AGE, 10'd0, 1'b0, 1'b0, 2'd0, 32'h8000_0000));
		send_beat(make_beat(OP_REMOVE, 10'd77, 1'b0, 1'b0, 2'd0, 32'd0));
		send_beat(make_beat(OP_REMOVE, 10'h3FF, 1'b0, 1'b0, 2'd0, 32'd0));
		for (n = 0; n < 15; n++)
			send_beat(make_beat(OP_INSERT, 10'(n + 100), n[0], n[1], 2'(n), 32'(n)));
		send_beat(make_beat(OP_INSERT, 10'd1, 1'b1, 1'b1, 2'd0, 32'd0));

		// Random phases; the queue contents carry over between settings.
		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_all(16'd10, 16'd20, 16'd50, 16'd60);
				1: set_all(16'd0, 16'd0, 16'd0, 16'd0);
				2: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: set_all(16'hFFF0, 16'd3, 16'd1, 16'd1);
				default: set_all(16'($urandom), 16'($urandom_range(0, 100)),
					16'($urandom_range(0, 100)), 16'($urandom_range(0, 200)));
			endcase
			no_idle = (phase == 4);
			for (n = 0; n < 250; n++) send_beat(random_beat());
		end
		no_idle = 0;

		drain();
		repeat (30) @(negedge clk);
		if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/apq_pkg.sv
hw/rtl/apq_cell.sv
hw/rtl/aging_priority_queue.sv
tb/tb_aging_priority_queue.sv
